// ===== hdl/rkal_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkal_pkg: shared types and constants for the rank array list
// Sizes, request codes, controller/datapath command and status structs,
// and the element width conversion helpers.
// ----------------------------------------------------------------------------
package rkal_pkg;

    localparam int CAPACITY   = 128;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [1:0] REQ_READ    = 2'd0;
    localparam logic [1:0] REQ_REPLACE = 2'd1;
    localparam logic [1:0] REQ_INSERT  = 2'd2;
    localparam logic [1:0] REQ_REMOVE  = 2'd3;

    // memory address source
    typedef enum logic [1:0] {
        SEL_RANK,
        SEL_PTR,
        SEL_PTR_DN,
        SEL_PTR_UP
    } addr_sel_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LOAD_COUNT,
        PTR_LOAD_RANK,
        PTR_DEC,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic      load;       // latch request
        logic      rd_en;
        addr_sel_t rd_sel;
        logic      wr_en;
        addr_sel_t wr_sel;
        logic      wr_req;     // write request value, else moved element
        ptr_op_t   ptr_op;
        cnt_op_t   cnt_op;
        logic      finish;     // load result registers
        logic      ok;
        logic      show_read;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       in_range;  // rank < count
        logic       ins_ok;    // rank <= count and not full
        logic       ptr_at_rank;
        logic       ptr_at_top; // ptr == count - 1
    } dp_status_t;

    function automatic logic [DATA_WIDTH-1:0] to_data(input logic signed [31:0] v);
        logic [63:0] e;
        e = 64'(v);
        return e[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] from_data(input logic [DATA_WIDTH-1:0] d);
        logic signed [DATA_WIDTH-1:0] s;
        logic [63:0] e;
        s = signed'(d);
        e = 64'(s);
        return e[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rkal_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkal_datapath: element memory, fill count and result registers
// Single-port-style element store with a move pointer; carries out the
// reads, writes and pointer/count updates the controller asks for.
// ----------------------------------------------------------------------------
module rkal_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rkal_pkg::ctrl_cmd_t    cmd,
    output rkal_pkg::dp_status_t        status,
    input  wire logic [1:0]             req_type,
    input  wire logic [7:0]             rank,
    input  wire logic signed [31:0]     value,
    output logic signed [31:0]          read_value,
    output logic                        ok,
    output logic [7:0]                  count,
    output logic                        empty_res
);
    import rkal_pkg::*;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    logic [1:0]            op_reg;
    logic [7:0]            rank_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [ADDR_W-1:0]     ptr_reg;
    logic [ADDR_W-1:0]     ptr_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      count_m1;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic signed [31:0]    read_value_reg;
    logic                  ok_reg;
    logic [7:0]            count_out_reg;
    logic                  empty_reg;

    logic [ADDR_W-1:0]     rank_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    assign rank_addr = ADDR_W'(rank_reg);
    assign count_m1  = count_reg - CNT_W'(1);

    function automatic logic [ADDR_W-1:0] pick(input addr_sel_t s,
                                               input logic [ADDR_W-1:0] r,
                                               input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] a;
        unique case (s)
            SEL_RANK:   a = r;
            SEL_PTR:    a = p;
            SEL_PTR_DN: a = p - ADDR_W'(1);
            SEL_PTR_UP: a = p + ADDR_W'(1);
            default:    a = r;
        endcase
        return a;
    endfunction

    assign rd_addr = pick(cmd.rd_sel, rank_addr, ptr_reg);
    assign wr_addr = pick(cmd.wr_sel, rank_addr, ptr_reg);
    assign wr_data = cmd.wr_req ? data_reg : rd_data_reg;

    always_comb
    begin
        unique case (cmd.ptr_op)
            PTR_LOAD_COUNT: ptr_next = ADDR_W'(count_reg);
            PTR_LOAD_RANK:  ptr_next = rank_addr;
            PTR_DEC:        ptr_next = ptr_reg - ADDR_W'(1);
            PTR_INC:        ptr_next = ptr_reg + ADDR_W'(1);
            default:        ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_m1;
            default: count_next = count_reg;
        endcase
    end

    // status for the controller
    assign status.op          = op_reg;
    assign status.in_range    = CMP_W'(rank_reg) < CMP_W'(count_reg);
    assign status.ins_ok      = (CMP_W'(rank_reg) <= CMP_W'(count_reg))
                              && (count_reg != CNT_W'(CAPACITY));
    assign status.ptr_at_rank = CMP_W'(ptr_reg) == CMP_W'(rank_reg);
    assign status.ptr_at_top  = CNT_W'(ptr_reg) == count_m1;

    // element store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // request, pointer and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req_type;
            rank_reg <= rank;
            data_reg <= to_data(value);
        end
        ptr_reg <= ptr_next;
        if (cmd.finish)
        begin
            read_value_reg <= cmd.show_read ? signed'(from_data(rd_data_reg)) : '0;
            ok_reg         <= cmd.ok;
            count_out_reg  <= 8'(count_next);
            empty_reg      <= (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign read_value = read_value_reg;
    assign ok         = ok_reg;
    assign count      = count_out_reg;
    assign empty_res  = empty_reg;

endmodule
`default_nettype wire

// ===== hdl/rkal_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkal_ctrl: request sequencer for the rank array list
// Checks range, steps element moves for insert and remove, and raises the
// result strobe.
// ----------------------------------------------------------------------------
module rkal_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    output logic                        done,
    input  wire rkal_pkg::dp_status_t   status,
    output rkal_pkg::ctrl_cmd_t         cmd
);
    import rkal_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ_OUT,
        S_INS_TEST,
        S_INS_MOVE,
        S_REM_TEST,
        S_REM_MOVE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        cmd        = '{load: 1'b0, rd_en: 1'b0, rd_sel: SEL_RANK, wr_en: 1'b0,
                       wr_sel: SEL_RANK, wr_req: 1'b0, ptr_op: PTR_HOLD,
                       cnt_op: CNT_HOLD, finish: 1'b0, ok: 1'b0,
                       show_read: 1'b0};
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                unique case (status.op)
                    REQ_READ:
                    begin
                        if (status.in_range)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = SEL_RANK;
                            state_next = S_READ_OUT;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    REQ_REPLACE:
                    begin
                        if (status.in_range)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = SEL_RANK;
                            cmd.wr_req = 1'b1;
                            cmd.ok     = 1'b1;
                        end
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    REQ_INSERT:
                    begin
                        if (status.ins_ok)
                        begin
                            cmd.ptr_op = PTR_LOAD_COUNT;
                            state_next = S_INS_TEST;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (status.in_range)
                        begin
                            cmd.ptr_op = PTR_LOAD_RANK;
                            state_next = S_REM_TEST;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ_OUT:
            begin
                cmd.finish    = 1'b1;
                cmd.ok        = 1'b1;
                cmd.show_read = 1'b1;
                state_next    = S_IDLE;
            end
            S_INS_TEST:
            begin
                if (status.ptr_at_rank)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = SEL_RANK;
                    cmd.wr_req = 1'b1;
                    cmd.cnt_op = CNT_INC;
                    cmd.finish = 1'b1;
                    cmd.ok     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = SEL_PTR_DN;
                    state_next = S_INS_MOVE;
                end
            end
            S_INS_MOVE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_PTR;
                cmd.ptr_op = PTR_DEC;
                state_next = S_INS_TEST;
            end
            S_REM_TEST:
            begin
                if (status.ptr_at_top)
                begin
                    cmd.cnt_op = CNT_DEC;
                    cmd.finish = 1'b1;
                    cmd.ok     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = SEL_PTR_UP;
                    state_next = S_REM_MOVE;
                end
            end
            S_REM_MOVE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_PTR;
                cmd.ptr_op = PTR_INC;
                state_next = S_REM_TEST;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

// ===== hdl/rank_array_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rank_array_list: rank-indexed list with read, replace, insert and remove
// Up to CAPACITY elements held in a memory; insert moves the elements at and
// above the rank up one place, remove moves those above it down one place.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload                              dir
//  request   start, busy        req_type, rank, value                in
//  result    done (strobe)      read_value, ok, count, empty_res     out
//
//  A request is taken on a clock edge with start high and busy low.
//  Each moved element takes a read of the element memory and then a write,
//  in separate states: the controller never reads and writes it together.
//  The result is strobed by done for one cycle after the request finishes;
//  the receiver cannot stall it. Reset clears the count; the element store
//  is not cleared and needs no clearing pass.
//
module rank_array_list (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         req_type,
    input  wire logic [7:0]         rank,
    input  wire logic signed [31:0] value,
    output logic                    done,
    output logic signed [31:0]      read_value,
    output logic                    ok,
    output logic [7:0]              count,
    output logic                    empty_res
);
    import rkal_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: range checks and move stepping
    rkal_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .cmd    (cmd)
    );

    // element store, count and result registers
    rkal_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .req_type   (req_type),
        .rank       (rank),
        .value      (value),
        .read_value (read_value),
        .ok         (ok),
        .count      (count),
        .empty_res  (empty_res)
    );

endmodule
`default_nettype wire
